[sv/ddo_pkg.sv]
package ddo_pkg;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_MPC = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ITW = 1'b1;

	localparam logic [23:0] MPC_RESET = 24'd21083;
	localparam logic [23:0] ITW_RESET = 24'd133747;

	localparam int TWO_PI_Q = 411775;
	localparam int PI_Q = 205887;
	localparam int HALF_PI_Q = 102944;
	localparam int CORDIC_GAIN = 652032874;
	localparam int USEC = 1000000;

	// Remainder by two pi: 2^21 mod TWO_PI_Q folds the bits above bit 20 back in.
	localparam logic [15:0] REM_FOLD_K = 16'd38277;
	localparam logic [3:0] REM_FOLDS = 4'd6;
	localparam logic [3:0] REM_LAST = 4'd8;

	localparam logic signed [63:0] MAX32 = 64'sd2147483647;
	localparam logic signed [63:0] MIN32 = -64'sd2147483648;

	typedef struct packed {
		logic signed [15:0] left_count;
		logic signed [15:0] right_count;
		logic [23:0] elapsed_us;
	} req_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [19:0] heading;
		logic signed [31:0] lin_velocity;
		logic signed [31:0] ang_velocity;
	} res_t;

	// Steps of the per-request sequence, in execution order.
	typedef enum logic [3:0] {
		OP_SUMQ,
		OP_DIFFQ,
		OP_TURN,
		OP_HALF_RED,
		OP_COS_HALF,
		OP_TRIG_OLD,
		OP_U,
		OP_DX,
		OP_DY,
		OP_HEAD,
		OP_TRIG_NEW,
		OP_WQ,
		OP_WTH,
		OP_VQ,
		OP_V,
		OP_VX
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_EMIT
	} state_t;

	typedef struct packed {
		op_t op;
		logic go;
		logic load_in;
		logic load_out;
	} cmd_t;

	function automatic logic [15:0] atan_q16(input logic [3:0] i);
		logic [15:0] r;
		case (i)
			4'd0: r = 16'd51472;
			4'd1: r = 16'd30386;
			4'd2: r = 16'd16055;
			4'd3: r = 16'd8150;
			4'd4: r = 16'd4091;
			4'd5: r = 16'd2047;
			4'd6: r = 16'd1024;
			4'd7: r = 16'd512;
			4'd8: r = 16'd256;
			4'd9: r = 16'd128;
			4'd10: r = 16'd64;
			4'd11: r = 16'd32;
			4'd12: r = 16'd16;
			4'd13: r = 16'd8;
			4'd14: r = 16'd4;
			4'd15: r = 16'd2;
			default: r = 16'd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > MAX32) begin
			r = 32'sh7FFFFFFF;
		end else if (v < MIN32) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// Saturate by the sign of a value: positive limit, negative limit or zero.
	function automatic logic signed [31:0] sat_sign(input logic neg, input logic nz);
		logic signed [31:0] r;
		if (!nz) begin
			r = 32'sd0;
		end else if (neg) begin
			r = 32'sh80000000;
		end else begin
			r = 32'sh7FFFFFFF;
		end
		return r;
	endfunction

endpackage

[sv/ddo_mul.sv]
module ddo_mul import ddo_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [43:0] a,
	input logic signed [35:0] b,
	output logic done,
	output logic signed [79:0] p
);

	logic [43:0] amag;
	logic [35:0] bmag;
	logic [79:0] mc_q;
	logic [79:0] acc_q;
	logic [35:0] mp_q;
	logic neg_q;
	logic busy_q;
	logic done_q;
	logic [5:0] cnt_q;

	assign amag = a[43] ? 44'(-a) : 44'(a);
	assign bmag = b[35] ? 36'(-b) : 36'(b);

	// One multiplier bit per cycle, shift and add on magnitudes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd35) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= a[43] ^ b[35];
			mc_q <= 80'(amag);
			mp_q <= bmag;
			acc_q <= '0;
		end else if (busy_q) begin
			if (mp_q[0]) begin
				acc_q <= acc_q + mc_q;
			end
			mc_q <= {mc_q[78:0], 1'b0};
			mp_q <= {1'b0, mp_q[35:1]};
		end
	end

	assign done = done_q;
	assign p = neg_q ? -$signed(acc_q) : $signed(acc_q);

endmodule

[sv/ddo_div.sv]
module ddo_div import ddo_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [63:0] n,
	input logic signed [24:0] d,
	output logic done,
	output logic signed [63:0] q
);

	logic [63:0] nmag;
	logic [23:0] dmag;
	logic [63:0] nq_q;
	logic [24:0] rem_q;
	logic [23:0] dmag_q;
	logic [24:0] trial;
	logic qneg_q;
	logic busy_q;
	logic done_q;
	logic [5:0] cnt_q;

	assign nmag = n[63] ? 64'(-n) : 64'(n);
	assign dmag = d[24] ? 24'(-d) : 24'(d);
	assign trial = {rem_q[23:0], nq_q[63]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Restoring division, one quotient bit per cycle; truncating signs.
	always_ff @(posedge clk) begin
		if (start) begin
			nq_q <= nmag;
			rem_q <= '0;
			dmag_q <= dmag;
			qneg_q <= n[63] ^ d[24];
		end else if (busy_q) begin
			if (trial >= {1'b0, dmag_q}) begin
				rem_q <= trial - {1'b0, dmag_q};
				nq_q <= {nq_q[62:0], 1'b1};
			end else begin
				rem_q <= trial;
				nq_q <= {nq_q[62:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign q = qneg_q ? -$signed(nq_q) : $signed(nq_q);

endmodule

// Truncated remainder by two pi. Six folding steps bring the magnitude below
// about 2.2 million, then three compare and subtract steps by four, two and
// one times two pi finish it; the sign follows the dividend.
module ddo_rem import ddo_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [43:0] n,
	output logic done,
	output logic signed [19:0] r
);

	logic [43:0] nmag;
	logic [43:0] acc_q;
	logic [38:0] fold_hi;
	logic [43:0] fold;
	logic [43:0] sub_k;
	logic [43:0] acc_d;
	logic neg_q;
	logic busy_q;
	logic done_q;
	logic [3:0] cnt_q;

	assign nmag = n[43] ? 44'(-n) : 44'(n);
	assign fold_hi = acc_q[43:21] * REM_FOLD_K;
	assign fold = 44'(fold_hi) + 44'(acc_q[20:0]);

	always_comb begin
		case (cnt_q)
			4'd6: sub_k = 44'(TWO_PI_Q) << 2;
			4'd7: sub_k = 44'(TWO_PI_Q) << 1;
			default: sub_k = 44'(TWO_PI_Q);
		endcase
		if (cnt_q < REM_FOLDS) begin
			acc_d = fold;
		end else if (acc_q >= sub_k) begin
			acc_d = acc_q - sub_k;
		end else begin
			acc_d = acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == REM_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= nmag;
			neg_q <= n[43];
		end else if (busy_q) begin
			acc_q <= acc_d;
		end
	end

	assign done = done_q;
	assign r = neg_q ? -$signed(acc_q[19:0]) : $signed(acc_q[19:0]);

endmodule

[sv/ddo_cordic.sv]
module ddo_cordic import ddo_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [19:0] angle,
	output logic done,
	output logic signed [32:0] cos_o,
	output logic signed [32:0] sin_o
);

	logic signed [20:0] r0;
	logic signed [20:0] r1;
	logic signed [20:0] rf;
	logic negf;
	logic signed [32:0] x_q;
	logic signed [32:0] y_q;
	logic signed [20:0] z_q;
	logic signed [32:0] xs;
	logic signed [32:0] ys;
	logic signed [20:0] at;
	logic neg_q;
	logic busy_q;
	logic done_q;
	logic [3:0] cnt_q;

	// Fold the angle into the range of plus or minus half pi.
	always_comb begin
		r0 = 21'(angle);
		if (r0 > 21'(PI_Q)) begin
			r1 = r0 - 21'(TWO_PI_Q);
		end else if (r0 < -21'(PI_Q)) begin
			r1 = r0 + 21'(TWO_PI_Q);
		end else begin
			r1 = r0;
		end
		negf = 1'b0;
		rf = r1;
		if (r1 > 21'(HALF_PI_Q)) begin
			rf = r1 - 21'(PI_Q);
			negf = 1'b1;
		end else if (r1 < -21'(HALF_PI_Q)) begin
			rf = r1 + 21'(PI_Q);
			negf = 1'b1;
		end
	end

	assign xs = x_q >>> cnt_q;
	assign ys = y_q >>> cnt_q;
	assign at = 21'(atan_q16(cnt_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= 33'(CORDIC_GAIN);
			y_q <= '0;
			z_q <= rf;
			neg_q <= negf;
		end else if (busy_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign done = done_q;
	assign cos_o = neg_q ? -x_q : x_q;
	assign sin_o = neg_q ? -y_q : y_q;

endmodule

[sv/ddo_dp.sv]
module ddo_dp import ddo_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cmd_t cmd,
	input req_t req_data,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [23:0] cfg_data,
	output res_t res_data,
	output logic done
);

	logic [23:0] mpc_q;
	logic [23:0] itw_q;
	logic signed [31:0] pose_x_q;
	logic signed [31:0] pose_y_q;
	logic signed [19:0] pose_h_q;
	logic signed [15:0] last_l_q;
	logic signed [15:0] last_r_q;
	req_t req_q;
	res_t res_q;

	logic signed [32:0] dist_q;
	logic signed [33:0] t1_q;
	logic signed [41:0] turn_q;
	logic signed [19:0] rh_q;
	logic signed [32:0] ch_q;
	logic signed [32:0] co_q;
	logic signed [32:0] so_q;
	logic signed [35:0] u_q;
	logic signed [35:0] dx_q;
	logic signed [35:0] dy_q;
	logic signed [19:0] hd_q;
	logic signed [18:0] c16_q;
	logic signed [63:0] wq_q;
	logic signed [63:0] vq_q;
	logic signed [63:0] v_q;
	logic signed [31:0] wth_q;
	logic signed [31:0] vx_q;

	logic signed [16:0] dl;
	logic signed [16:0] dr;
	logic dt_zero;

	logic mul_start;
	logic signed [43:0] mul_a;
	logic signed [35:0] mul_b;
	logic mul_done;
	logic signed [79:0] mul_p;

	logic div_start;
	logic signed [63:0] div_n;
	logic signed [24:0] div_d;
	logic div_done;
	logic signed [63:0] div_q;

	logic rem_start;
	logic signed [43:0] rem_n;
	logic rem_done;
	logic signed [19:0] rem_r;

	logic cor_start;
	logic signed [19:0] cor_a;
	logic cor_done;
	logic signed [32:0] cor_c;
	logic signed [32:0] cor_s;

	logic signed [63:0] px_sum;
	logic signed [63:0] py_sum;
	logic v_ovf;

	assign dl = 17'(req_q.left_count) - 17'(last_l_q);
	assign dr = 17'(req_q.right_count) - 17'(last_r_q);
	assign dt_zero = (req_q.elapsed_us == 24'd0);
	assign px_sum = 64'(pose_x_q) + 64'(dx_q);
	assign py_sum = 64'(pose_y_q) + 64'(dy_q);
	assign v_ovf = (v_q > MAX32) || (v_q < MIN32);

	always_comb begin
		mul_start = cmd.go && (cmd.op inside {OP_SUMQ, OP_DIFFQ, OP_TURN, OP_U, OP_DX,
			OP_DY, OP_WQ, OP_VQ});
		div_start = cmd.go && (cmd.op inside {OP_WTH, OP_V, OP_VX});
		rem_start = cmd.go && (cmd.op inside {OP_HALF_RED, OP_HEAD});
		cor_start = cmd.go && (cmd.op inside {OP_COS_HALF, OP_TRIG_OLD, OP_TRIG_NEW});
		mul_a = '0;
		mul_b = '0;
		div_n = '0;
		div_d = '0;
		rem_n = '0;
		cor_a = '0;
		case (cmd.op)
			OP_SUMQ: begin
				mul_a = 44'(18'(dl) + 18'(dr));
				mul_b = $signed(36'(mpc_q));
			end
			OP_DIFFQ: begin
				mul_a = 44'(18'(dr) - 18'(dl));
				mul_b = $signed(36'(mpc_q));
			end
			OP_TURN: begin
				mul_a = 44'(t1_q);
				mul_b = $signed(36'(itw_q));
			end
			OP_HALF_RED: rem_n = 44'(turn_q >>> 1);
			OP_COS_HALF: cor_a = rh_q;
			OP_TRIG_OLD: cor_a = pose_h_q;
			OP_U: begin
				mul_a = 44'(dist_q);
				mul_b = 36'(ch_q);
			end
			OP_DX: begin
				mul_a = 44'(u_q);
				mul_b = 36'(co_q);
			end
			OP_DY: begin
				mul_a = 44'(u_q);
				mul_b = 36'(so_q);
			end
			OP_HEAD: rem_n = 44'(pose_h_q) + 44'(turn_q);
			OP_TRIG_NEW: cor_a = hd_q;
			OP_WQ: begin
				mul_a = 44'(turn_q);
				mul_b = 36'(USEC);
			end
			OP_WTH: begin
				div_n = wq_q;
				div_d = $signed({1'b0, req_q.elapsed_us});
			end
			OP_VQ: begin
				mul_a = 44'(dx_q);
				mul_b = 36'(USEC);
			end
			OP_V: begin
				div_n = vq_q;
				div_d = $signed({1'b0, req_q.elapsed_us});
			end
			OP_VX: begin
				div_n = $signed({v_q[47:0], 16'd0});
				div_d = 25'(c16_q);
			end
			default: ;
		endcase
	end

	assign done = mul_done | div_done | rem_done | cor_done;

	ddo_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .p(mul_p)
	);

	ddo_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .n(div_n), .d(div_d),
		.done(div_done), .q(div_q)
	);

	ddo_rem u_rem (
		.clk(clk), .arst_n(arst_n), .start(rem_start), .n(rem_n),
		.done(rem_done), .r(rem_r)
	);

	ddo_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cor_start), .angle(cor_a),
		.done(cor_done), .cos_o(cor_c), .sin_o(cor_s)
	);

	// Architectural state: configuration, pose and last counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mpc_q <= MPC_RESET;
			itw_q <= ITW_RESET;
			pose_x_q <= '0;
			pose_y_q <= '0;
			pose_h_q <= '0;
			last_l_q <= '0;
			last_r_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MPC: mpc_q <= cfg_data;
					CFG_ITW: itw_q <= cfg_data;
					default: ;
				endcase
			end
			if (rem_done && cmd.op == OP_HEAD) begin
				pose_x_q <= sat32(px_sum);
				pose_y_q <= sat32(py_sum);
				pose_h_q <= rem_r;
				last_l_q <= req_q.left_count;
				last_r_q <= req_q.right_count;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			req_q <= req_data;
		end
		if (mul_done) begin
			case (cmd.op)
				OP_SUMQ: dist_q <= mul_p[41:9];
				OP_DIFFQ: t1_q <= mul_p[41:8];
				OP_TURN: turn_q <= mul_p[57:16];
				OP_U: u_q <= mul_p[65:30];
				OP_DX: dx_q <= mul_p[65:30];
				OP_DY: dy_q <= mul_p[65:30];
				OP_WQ: wq_q <= mul_p[63:0];
				OP_VQ: vq_q <= mul_p[63:0];
				default: ;
			endcase
		end
		if (rem_done) begin
			case (cmd.op)
				OP_HALF_RED: rh_q <= rem_r;
				OP_HEAD: hd_q <= rem_r;
				default: ;
			endcase
		end
		if (div_done) begin
			case (cmd.op)
				OP_WTH: begin
					if (dt_zero) begin
						wth_q <= sat_sign(turn_q[41], turn_q != '0);
					end else begin
						wth_q <= sat32(div_q);
					end
				end
				OP_V: v_q <= div_q;
				OP_VX: begin
					if (dt_zero || c16_q == '0) begin
						vx_q <= sat_sign(dx_q[35], dx_q != '0);
					end else if (v_ovf) begin
						vx_q <= sat_sign(v_q[63] != c16_q[18], 1'b1);
					end else begin
						vx_q <= sat32(div_q);
					end
				end
				default: ;
			endcase
		end
		if (cor_done) begin
			case (cmd.op)
				OP_COS_HALF: ch_q <= cor_c;
				OP_TRIG_OLD: begin
					co_q <= cor_c;
					so_q <= cor_s;
				end
				OP_TRIG_NEW: c16_q <= cor_c[32:14];
				default: ;
			endcase
		end
		if (cmd.load_out) begin
			res_q.pos_x <= pose_x_q;
			res_q.pos_y <= pose_y_q;
			res_q.heading <= hd_q;
			res_q.lin_velocity <= vx_q;
			res_q.ang_velocity <= wth_q;
		end
	end

	assign res_data = res_q;

endmodule

[sv/ddo_ctrl.sv]
module ddo_ctrl import ddo_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	output logic res_valid,
	input logic res_stall,
	input logic done,
	output cmd_t cmd
);

	state_t state_q, state_d;
	op_t op_q, op_d;
	logic issued_q, issued_d;
	logic res_valid_q, res_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= OP_SUMQ;
			issued_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q <= op_d;
			issued_q <= issued_d;
			res_valid_q <= res_valid_d;
		end
	end

	always_comb begin
		state_d = state_q;
		op_d = op_q;
		issued_d = issued_q;
		res_valid_d = res_valid_q;
		cmd.op = op_q;
		cmd.go = 1'b0;
		cmd.load_in = 1'b0;
		cmd.load_out = 1'b0;
		if (res_valid_q && !res_stall) begin
			res_valid_d = 1'b0;
		end
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load_in = 1'b1;
					op_d = OP_SUMQ;
					issued_d = 1'b0;
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				cmd.go = !issued_q;
				if (!issued_q) begin
					issued_d = 1'b1;
				end else if (done) begin
					issued_d = 1'b0;
					if (op_q == OP_VX) begin
						state_d = ST_EMIT;
					end else begin
						op_d = op_t'(4'(op_q) + 4'd1);
					end
				end
			end
			ST_EMIT: begin
				if (!res_valid_q || !res_stall) begin
					cmd.load_out = 1'b1;
					res_valid_d = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign req_stall = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;

	a_go_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.go |-> state_q == ST_CALC)
		else $error("unit started outside the calculation phase");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!res_valid_q || !res_stall))
		else $error("result register overwritten while held");

	a_start_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && req_valid) |=> (state_q == ST_CALC && op_q == OP_SUMQ))
		else $error("accepted request did not start the sequence");

endmodule

[sv/diff_drive_odometry.sv]
// Each accepted request runs eight bit-serial multiplies, three restoring
// divides, two remainder runs and three CORDIC runs, issued one after another.
// No new request is taken while one is in flight; the next is taken once the
// result has moved into the output register, even if it has not been taken.
// Reset clears the pose, the last counts and the handshake state, and loads the
// default scale registers.
module diff_drive_odometry import ddo_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input req_t req_data,
	output logic res_valid,
	input logic res_stall,
	output res_t res_data,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [23:0] cfg_data
);

	// The controller walks a fixed list of steps; each step starts one of the
	// shared arithmetic units in the datapath and waits for its done pulse.
	cmd_t cmd;
	logic done;

	ddo_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.done(done),
		.cmd(cmd)
	);

	// The datapath holds the pose, the previous counts, the scale registers,
	// the intermediate results and the output register.
	ddo_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.req_data(req_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.res_data(res_data),
		.done(done)
	);

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps

// Self-checking bench for the differential-drive odometry block. Requests carry
// absolute encoder counts and a time step. A small table of directed requests
// runs first, then several phases of random requests under different scale
// register settings. Every accepted request is run through a local fixed-point
// model of the odometry update, and each result is compared field by field
// against the oldest pending prediction.
module testbench;
	import ddo_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam longint CYCLE_LIMIT = 20000000;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_REQUESTS = 170;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req_data;
	logic res_valid;
	logic res_stall;
	res_t res_data;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [23:0] cfg_data;

	diff_drive_odometry i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data(res_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// Local copy of the odometry state and the two scale registers.
	longint odo_x, odo_y, odo_heading, odo_last_left, odo_last_right;
	longint odo_mpc, odo_itw;

	res_t pending_poses[$];
	int error_count;
	longint cycle_count;
	bit stimulus_done;

	// Arctangent steps of the CORDIC, Q.16 radians.
	const longint atan_steps[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2};

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic longint sign_limit(input longint v);
		if (v > 0) begin
			return 64'sd2147483647;
		end
		if (v < 0) begin
			return -64'sd2147483648;
		end
		return 0;
	endfunction

	// Cosine and sine in Q.30 of an angle in Q.16. The angle is folded into
	// plus or minus half pi first; a fold by pi flips the sign of both results.
	task automatic rotate(input longint angle, output longint c, output longint s);
		longint r, x, y, nx;
		bit flip;
		r = angle % TWO_PI_Q;
		x = CORDIC_GAIN;
		y = 0;
		flip = 1'b0;
		if (r > PI_Q) begin
			r -= TWO_PI_Q;
		end
		if (r < -PI_Q) begin
			r += TWO_PI_Q;
		end
		if (r > HALF_PI_Q) begin
			r -= PI_Q;
			flip = 1'b1;
		end else if (r < -HALF_PI_Q) begin
			r += PI_Q;
			flip = 1'b1;
		end
		for (int i = 0; i < 16; i++) begin
			if (r >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				r -= atan_steps[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				r += atan_steps[i];
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	// One odometry update: wheel travel, turn, pose advance and velocities.
	task automatic advance_odometry(input req_t rq, output res_t o);
		longint l, r, dt, dl, dr, travel, turn, ch, sh, co, so, cn, sn;
		longint u, dx, dy, hd, c16, vx, wth, v;
		l = rq.left_count;
		r = rq.right_count;
		dt = rq.elapsed_us;
		// Count differences are plain 17 bit values, never wrapped.
		dl = l - odo_last_left;
		dr = r - odo_last_right;
		travel = ((dl + dr) * odo_mpc) >>> 9;
		turn = ((((dr - dl) * odo_mpc) >>> 8) * odo_itw) >>> 16;
		rotate(turn >>> 1, ch, sh);
		rotate(odo_heading, co, so);
		u = (travel * ch) >>> 30;
		dx = (u * co) >>> 30;
		dy = (u * so) >>> 30;
		odo_x = clamp32(odo_x + dx);
		odo_y = clamp32(odo_y + dy);
		// Truncated remainder, so the heading keeps its sign.
		hd = (odo_heading + turn) % TWO_PI_Q;
		odo_heading = hd;
		odo_last_left = l;
		odo_last_right = r;
		rotate(hd, cn, sn);
		c16 = cn >>> 14;
		if (dt == 0) begin
			// No time has passed: both rates saturate by the sign of the motion.
			wth = sign_limit(turn);
			vx = sign_limit(dx);
		end else begin
			wth = clamp32(turn * longint'(USEC) / dt);
			if (c16 == 0) begin
				vx = sign_limit(dx);
			end else begin
				v = dx * longint'(USEC) / dt;
				if (v > 64'sd2147483647 || v < -64'sd2147483648) begin
					vx = sign_limit(((v > 0) == (c16 > 0)) ? 1 : -1);
				end else begin
					vx = clamp32(v * 65536 / c16);
				end
			end
		end
		o.pos_x = odo_x[31:0];
		o.pos_y = odo_y[31:0];
		o.heading = hd[19:0];
		o.lin_velocity = vx[31:0];
		o.ang_velocity = wth[31:0];
	endtask

	task automatic report_mismatch(input string field, input longint got, input longint want);
		$display("Mismatch at cycle %0d: %s is %0d, expected %0d", cycle_count, field, got,
			want);
		error_count++;
	endtask

	// Register writes happen only while nothing is in flight.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == CFG_MPC) begin
			odo_mpc = value;
		end else begin
			odo_itw = value;
		end
	endtask

	task automatic wait_drained();
		wait (pending_poses.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	// Drives one request from a falling edge and holds it until the block takes
	// it. Stall is read shortly after the falling edge, so it is the value the
	// next rising edge sees. The prediction is queued with the acceptance.
	task automatic send_request(input req_t rq, input bit typed, input res_t typed_res);
		res_t predicted;
		bit taken;
		taken = 1'b0;
		@(negedge clk);
		req_valid = 1'b1;
		req_data = rq;
		while (!taken) begin
			#1;
			if (!req_stall) begin
				taken = 1'b1;
				advance_odometry(rq, predicted);
				pending_poses.push_back(typed ? typed_res : predicted);
			end
			@(negedge clk);
		end
		req_valid = 1'b0;
	endtask

	// Gap before a request: mostly none or short, now and then long.
	task automatic idle_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			return;
		end else if (pick < 95) begin
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end else begin
			repeat ($urandom_range(200, 1500)) @(negedge clk);
		end
	endtask

	// Receiver: a random stall at every falling edge, in stretches of several
	// modes, and the check of whatever the next rising edge accepts.
	int stall_left;
	int stall_mode;
	int mode_left;
	always @(negedge clk) begin
		if (arst_n) begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_left = $urandom_range(500, 5000);
			end else begin
				mode_left--;
			end
			if (stall_left > 0) begin
				res_stall = 1'b1;
				stall_left--;
			end else if (stall_mode != 0 && $urandom_range(0, 99) < 25) begin
				res_stall = 1'b1;
				if (stall_mode == 2 && $urandom_range(0, 19) == 0) begin
					stall_left = $urandom_range(50, 800);
				end else begin
					stall_left = $urandom_range(0, 4);
				end
			end else begin
				res_stall = 1'b0;
			end
			#1;
			if (res_valid && !res_stall) begin
				if (pending_poses.size() == 0) begin
					$display("Unexpected result at cycle %0d", cycle_count);
					error_count++;
				end else begin
					res_t want;
					want = pending_poses.pop_front();
					if (res_data.pos_x !== want.pos_x) begin
						report_mismatch("pos_x", res_data.pos_x, want.pos_x);
					end
					if (res_data.pos_y !== want.pos_y) begin
						report_mismatch("pos_y", res_data.pos_y, want.pos_y);
					end
					if (res_data.heading !== want.heading) begin
						report_mismatch("heading", res_data.heading, want.heading);
					end
					if (res_data.lin_velocity !== want.lin_velocity) begin
						report_mismatch("lin_velocity", res_data.lin_velocity,
							want.lin_velocity);
					end
					if (res_data.ang_velocity !== want.ang_velocity) begin
						report_mismatch("ang_velocity", res_data.ang_velocity,
							want.ang_velocity);
					end
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	typedef struct {
		logic signed [15:0] left;
		logic signed [15:0] right;
		logic [23:0] dt;
		bit typed;
	} directed_row_t;

	// Directed rows at the reset scale settings. The first two cause no motion
	// from the reset pose, so the whole result is zero.
	directed_row_t directed_rows[] = '{
		'{16'sd0, 16'sd0, 24'd1000, 1'b1},
		'{16'sd0, 16'sd0, 24'd0, 1'b1},
		'{16'sd100, 16'sd100, 24'd100000, 1'b0},
		'{16'sd100, 16'sd300, 24'd0, 1'b0},
		'{16'sd100, 16'sd100, 24'd0, 1'b0},
		'{-16'sd200, -16'sd400, 24'd50000, 1'b0},
		'{16'sd32767, -16'sd32768, 24'd1, 1'b0},
		'{-16'sd32768, 16'sd32767, 24'd16777215, 1'b0},
		'{-16'sd32768, 16'sd32767, 24'd1, 1'b0},
		'{16'sd32767, 16'sd32767, 24'd1, 1'b0},
		'{-16'sd32768, -16'sd32768, 24'd16777215, 1'b0},
		'{16'sd0, 16'sd0, 24'd20000, 1'b0},
		'{-16'sd1200, 16'sd1200, 24'd100000, 1'b0},
		'{-16'sd2400, 16'sd2400, 24'd100000, 1'b0},
		'{-16'sd3600, 16'sd3600, 24'd100000, 1'b0},
		'{-16'sd4800, 16'sd4800, 24'd100000, 1'b0},
		'{-16'sd4000, 16'sd5600, 24'd8, 1'b0},
		'{16'sd5000, -16'sd5000, 24'd100000, 1'b0},
		'{16'sd15000, -16'sd15000, 24'd100000, 1'b0},
		'{16'sd15100, -16'sd14900, 24'd10000, 1'b0},
		'{16'sd15100, -16'sd14900, 24'd16777215, 1'b0}
	};

	// Scale register settings of the random phases, extremes included.
	logic [23:0] phase_mpc[RANDOM_PHASES] = '{MPC_RESET, 24'hFFFFFF, 24'd0, 24'd1,
		24'd400000, 24'hFFFFFF};
	logic [23:0] phase_itw[RANDOM_PHASES] = '{ITW_RESET, 24'hFFFFFF, 24'd2000000, 24'd0,
		24'd65536, 24'd1};

	logic signed [15:0] walk_left, walk_right;

	// Random request: mostly a short wheel move from the last counts with a
	// sensible time step, sometimes a wild jump or an extreme.
	task automatic random_request(output req_t rq);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 75) begin
			walk_left = walk_left + 16'($signed($urandom_range(0, 600)) - 300);
			walk_right = walk_right + 16'($signed($urandom_range(0, 600)) - 300);
		end else if (pick < 85) begin
			walk_left = 16'($urandom);
			walk_right = 16'($urandom);
		end else if (pick < 92) begin
			walk_left = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			walk_right = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
		end
		rq.left_count = walk_left;
		rq.right_count = walk_right;
		pick = $urandom_range(0, 99);
		if (pick < 65) begin
			rq.elapsed_us = 24'($urandom_range(1000, 200000));
		end else if (pick < 75) begin
			rq.elapsed_us = 24'd0;
		end else if (pick < 85) begin
			rq.elapsed_us = 24'($urandom_range(1, 10));
		end else begin
			rq.elapsed_us = 24'($urandom);
		end
	endtask

	initial begin
		req_t rq;
		res_t zero_res;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		res_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_MPC;
		cfg_data = '0;
		error_count = 0;
		cycle_count = 0;
		stall_left = 0;
		stall_mode = 0;
		mode_left = 0;
		zero_res = '0;
		odo_x = 0;
		odo_y = 0;
		odo_heading = 0;
		odo_last_left = 0;
		odo_last_right = 0;
		odo_mpc = MPC_RESET;
		odo_itw = ITW_RESET;
		walk_left = 0;
		walk_right = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[k]) begin
			rq.left_count = directed_rows[k].left;
			rq.right_count = directed_rows[k].right;
			rq.elapsed_us = directed_rows[k].dt;
			send_request(rq, directed_rows[k].typed, zero_res);
			idle_gap();
		end
		walk_left = rq.left_count;
		walk_right = rq.right_count;

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			wait_drained();
			write_register(CFG_MPC, phase_mpc[p]);
			write_register(CFG_ITW, phase_itw[p]);
			for (int n = 0; n < PHASE_REQUESTS; n++) begin
				random_request(rq);
				send_request(rq, 1'b0, zero_res);
				// Once in a while the sender holds off until all results are in.
				if (n == PHASE_REQUESTS / 2) begin
					wait (pending_poses.size() == 0);
				end else begin
					idle_gap();
				end
			end
		end

		// Drain, then give a stray extra result time to show up.
		wait (pending_poses.size() == 0);
		repeat (1000) @(posedge clk);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

[diff_drive_odometry.f]
sv/ddo_pkg.sv
sv/ddo_mul.sv
sv/ddo_div.sv
sv/ddo_cordic.sv
sv/ddo_dp.sv
sv/ddo_ctrl.sv
sv/diff_drive_odometry.sv
test/testbench.sv
